>>> design/rlm_pkg.sv
// shared types, constants and register codes of the run-queue latency monitor
package rlm_pkg;

    localparam int TASK_IDS_DEF = 1024;

    localparam int ID_W     = 10;
    localparam int GRP_W    = 10;
    localparam int TS_W     = 64;
    localparam int CPU_W    = 8;
    localparam int PRIO_W   = 8;
    localparam int RATE_W   = 16;
    localparam int APB_DW   = 64;
    localparam int APB_AW   = 5;
    localparam int REG_LSB  = 3;
    localparam int STEP_W   = 6;

    localparam logic MODE_SWITCH = 1'b1;

    typedef enum logic [1:0] {
        REG_TARGET_GROUP,
        REG_MIN_LATENCY,
        REG_REPORT_STRIDE,
        REG_INCLUDE_KTHREADS
    } reg_idx_t;

    typedef struct packed {
        logic                mode;
        logic [TS_W-1:0]     timestamp;
        logic [CPU_W-1:0]    cpu_index;
        logic [ID_W-1:0]     task_id;
        logic [GRP_W-1:0]    group_id;
        logic                is_kernel_thread;
        logic [PRIO_W-1:0]   priority_req;
        logic [ID_W-1:0]     prev_task_id;
        logic [GRP_W-1:0]    prev_group_id;
        logic                prev_still_running;
    } in_t;

    typedef struct packed {
        logic [ID_W-1:0]     event_task_id;
        logic [GRP_W-1:0]    event_group_id;
        logic [TS_W-1:0]     event_latency;
        logic [TS_W-1:0]     event_timestamp;
        logic [CPU_W-1:0]    event_cpu;
        logic [PRIO_W-1:0]   event_priority;
    } out_t;

    typedef struct packed {
        logic [GRP_W-1:0]    target_group;
        logic [TS_W-1:0]     min_latency;
        logic [RATE_W-1:0]   report_stride;
        logic                include_kthreads;
    } cfg_t;

    typedef struct packed {
        logic clr_step;
        logic item_load;
        logic stamp_wr;
        logic prev_wr;
        logic rd_issue;
        logic lat_load;
        logic clr_entry;
        logic cnt_inc;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic new_mode;
        logic wake_ok;
        logic prev_ok;
        logic hit;
        logic lat_ok;
        logic sampling;
        logic div_last;
        logic rem_zero;
        logic out_free;
    } sts_t;

endpackage

>>> design/rlm_ram.sv
// generic single-write, single-read ram with registered read data
module rlm_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = rlm_pkg::TASK_IDS_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/rlm_dp.sv
// datapath: item register, task table, latency, sample counter, remainder unit, output register
module rlm_dp #(
    parameter int TASK_IDS = rlm_pkg::TASK_IDS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  rlm_pkg::in_t  s_data,
    input  rlm_pkg::cfg_t cfg,
    input  rlm_pkg::cmd_t cmd,
    output rlm_pkg::sts_t sts,
    input  logic          m_ready,
    output logic          m_valid,
    output rlm_pkg::out_t m_data
);

    localparam int AW = $clog2(TASK_IDS);
    localparam int EW = rlm_pkg::TS_W + 1;
    localparam int RW = rlm_pkg::RATE_W;

    rlm_pkg::in_t                item_reg;
    logic [rlm_pkg::TS_W-1:0]    lat_reg;
    logic [rlm_pkg::TS_W-1:0]    lat_next;
    logic [AW-1:0]               clr_addr_reg;
    logic [rlm_pkg::TS_W-1:0]    cnt_reg;
    logic [rlm_pkg::TS_W-1:0]    cnt_next;
    logic [rlm_pkg::TS_W-1:0]    div_q_reg;
    logic [RW-1:0]               rem_reg;
    logic [RW-1:0]               rem_next;
    logic [rlm_pkg::STEP_W-1:0]  div_cnt_reg;
    logic                        out_valid_reg;
    rlm_pkg::out_t               out_reg;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [EW-1:0]               ram_wdata;
    logic [EW-1:0]               ram_rdata;
    logic [AW-1:0]               tid_addr;
    logic [RW:0]                 shifted;
    logic [RW:0]                 rate_ext;

    logic grp_pass;
    logic pgrp_pass;
    logic tid_in;
    logic ptid_in;
    logic qual;

    assign tid_addr  = AW'(item_reg.task_id);
    assign grp_pass  = (cfg.target_group == '0) || (cfg.target_group == item_reg.group_id);
    assign pgrp_pass = (cfg.target_group == '0) || (cfg.target_group == item_reg.prev_group_id);
    assign tid_in    = (32'(item_reg.task_id) < 32'(TASK_IDS));
    assign ptid_in   = (32'(item_reg.prev_task_id) < 32'(TASK_IDS));
    assign qual      = (item_reg.task_id != '0) && (item_reg.group_id != '0)
                     && (cfg.include_kthreads || !item_reg.is_kernel_thread)
                     && grp_pass && tid_in;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = '0;
        if (cmd.clr_step) begin
            ram_we = 1'b1;
        end else if (cmd.stamp_wr) begin
            ram_we    = 1'b1;
            ram_waddr = tid_addr;
            ram_wdata = {1'b1, item_reg.timestamp};
        end else if (cmd.prev_wr) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(item_reg.prev_task_id);
            ram_wdata = {1'b1, item_reg.timestamp};
        end else if (cmd.clr_entry) begin
            ram_we    = 1'b1;
            ram_waddr = tid_addr;
        end
    end

    rlm_ram #(
        .WIDTH(EW),
        .DEPTH(TASK_IDS)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd.rd_issue),
        .raddr(tid_addr),
        .rdata(ram_rdata)
    );

    assign lat_next = item_reg.timestamp - ram_rdata[rlm_pkg::TS_W-1:0];
    assign cnt_next = cnt_reg + 64'd1;
    assign shifted  = {rem_reg, div_q_reg[rlm_pkg::TS_W-1]};
    assign rate_ext = {1'b0, cfg.report_stride};
    assign rem_next = (shifted >= rate_ext) ? RW'(shifted - rate_ext) : shifted[RW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            cnt_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.cnt_inc) begin
                cnt_reg     <= cnt_next;
                div_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + rlm_pkg::STEP_W'(1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            item_reg <= s_data;
        end
        if (cmd.lat_load) begin
            lat_reg <= lat_next;
        end
        if (cmd.cnt_inc) begin
            div_q_reg <= cnt_next;
            rem_reg   <= '0;
        end else if (cmd.div_step) begin
            div_q_reg <= {div_q_reg[rlm_pkg::TS_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
        if (cmd.out_load) begin
            out_reg.event_task_id   <= item_reg.task_id;
            out_reg.event_group_id  <= item_reg.group_id;
            out_reg.event_latency   <= lat_reg;
            out_reg.event_timestamp <= item_reg.timestamp;
            out_reg.event_cpu       <= item_reg.cpu_index;
            out_reg.event_priority  <= item_reg.priority_req;
        end
    end

    always_comb begin
        sts.clr_last = (clr_addr_reg == AW'(TASK_IDS - 1));
        sts.new_mode = s_data.mode;
        sts.wake_ok  = grp_pass && tid_in;
        sts.prev_ok  = item_reg.prev_still_running && pgrp_pass && ptid_in;
        sts.hit      = qual && ram_rdata[EW-1];
        sts.lat_ok   = (lat_reg >= cfg.min_latency);
        sts.sampling = (cfg.report_stride > RW'(1));
        sts.div_last = (div_cnt_reg == '1);
        sts.rem_zero = (rem_reg == '0);
        sts.out_free = !out_valid_reg || m_ready;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> design/rlm_ctrl.sv
// controller state machine sequencing table clear, stamps, lookup, sampling and output
module rlm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rlm_pkg::sts_t sts,
    output rlm_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_STAMP,
        S_RESTAMP,
        S_READ,
        S_EVAL,
        S_CMP,
        S_DIV,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.item_load = 1'b1;
                    state_next    = (sts.new_mode == rlm_pkg::MODE_SWITCH) ? S_RESTAMP : S_STAMP;
                end
            end
            S_STAMP: begin
                cmd.stamp_wr = sts.wake_ok;
                state_next   = S_IDLE;
            end
            S_RESTAMP: begin
                cmd.prev_wr = sts.prev_ok;
                state_next  = S_READ;
            end
            S_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EVAL;
            end
            S_EVAL: begin
                cmd.lat_load = 1'b1;
                if (sts.hit) begin
                    cmd.clr_entry = 1'b1;
                    state_next    = S_CMP;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_CMP: begin
                if (!sts.lat_ok) begin
                    state_next = S_IDLE;
                end else if (sts.sampling) begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_DIV;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = sts.rem_zero ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

>>> design/runqueue_latency_monitor.sv
// top level: run-queue latency monitor with apb register file
//
//  channel  direction  handshake          word
//  s_       in         s_valid/s_ready    rlm_pkg::in_t event
//  m_       out        m_valid/m_ready    rlm_pkg::out_t latency report
//  apb      in/out     psel/penable       64-bit register at 8*index
//
// after reset the task table is cleared, with s_ready low
// a wakeup stamps its task; a switch restamps the previous task, then reads the
// table and on a hit clears the entry; with report_stride above one a surviving
// switch passes the bit-serial remainder unit (one bit of the 64-bit count per cycle)
// one word at a time; a waiting report does not block the next word until
// another report is ready to be loaded
module runqueue_latency_monitor #(
    parameter int TASK_IDS = rlm_pkg::TASK_IDS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  rlm_pkg::in_t               s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output rlm_pkg::out_t              m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rlm_pkg::APB_AW-1:0] paddr,
    input  logic [rlm_pkg::APB_DW-1:0] pwdata,
    output logic [rlm_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    rlm_pkg::cfg_t     cfg_reg;
    rlm_pkg::cmd_t     cmd;
    rlm_pkg::sts_t     sts;
    rlm_pkg::reg_idx_t reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = rlm_pkg::reg_idx_t'(paddr[rlm_pkg::APB_AW-1:rlm_pkg::REG_LSB]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                rlm_pkg::REG_TARGET_GROUP: begin
                    cfg_reg.target_group <= pwdata[rlm_pkg::GRP_W-1:0];
                end
                rlm_pkg::REG_MIN_LATENCY: begin
                    cfg_reg.min_latency <= pwdata[rlm_pkg::TS_W-1:0];
                end
                rlm_pkg::REG_REPORT_STRIDE: begin
                    cfg_reg.report_stride <= pwdata[rlm_pkg::RATE_W-1:0];
                end
                rlm_pkg::REG_INCLUDE_KTHREADS: begin
                    cfg_reg.include_kthreads <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rlm_pkg::REG_TARGET_GROUP:     prdata = rlm_pkg::APB_DW'(cfg_reg.target_group);
            rlm_pkg::REG_MIN_LATENCY:      prdata = rlm_pkg::APB_DW'(cfg_reg.min_latency);
            rlm_pkg::REG_REPORT_STRIDE:    prdata = rlm_pkg::APB_DW'(cfg_reg.report_stride);
            rlm_pkg::REG_INCLUDE_KTHREADS: prdata = rlm_pkg::APB_DW'(cfg_reg.include_kthreads);
            default:                       prdata = '0;
        endcase
    end

    rlm_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    rlm_dp #(
        .TASK_IDS(TASK_IDS)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cfg    (cfg_reg),
        .cmd    (cmd),
        .sts    (sts),
        .m_ready(m_ready),
        .m_valid(m_valid),
        .m_data (m_data)
    );

endmodule

>>> design/rlm_checker.sv
// port-level checks of the run-queue latency monitor, bound to the top level
module rlm_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input rlm_pkg::out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("report dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("report changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in work");

    a_report_ids: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_data.event_task_id != '0) && (m_data.event_group_id != '0)
                           && $past(!s_ready))
        else $error("report with zero id or while idle");

endmodule

bind runqueue_latency_monitor rlm_checker u_rlm_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
